>>> src/tsd_pkg.sv
`timescale 1ns / 1ps

package tsd_pkg;

  // Character classes.
  localparam logic [2:0] CLS_ZERO  = 3'd0;
  localparam logic [2:0] CLS_DIGIT = 3'd1;
  localparam logic [2:0] CLS_HEX   = 3'd2;
  localparam logic [2:0] CLS_X     = 3'd3;
  localparam logic [2:0] CLS_ALPHA = 3'd4;
  localparam logic [2:0] CLS_END   = 3'd5;
  localparam logic [2:0] CLS_SPACE = 3'd6;
  localparam logic [2:0] CLS_OTHER = 3'd7;

  // Scanner rows.
  localparam logic [2:0] ROW_START = 3'd0;
  localparam logic [2:0] ROW_BAD   = 3'd5;
  localparam logic [2:0] ROW_ERR   = 3'd6;

  // Transition codes that are not plain row numbers.
  localparam logic [7:0] CODE_ID_OK   = 8'd100;
  localparam logic [7:0] CODE_INT_OK  = 8'd101;
  localparam logic [7:0] CODE_HEX_OK  = 8'd102;
  localparam logic [7:0] CODE_FDT_OK  = 8'd103;
  localparam logic [7:0] CODE_BAD_RUN = 8'd200;
  localparam logic [7:0] CODE_BAD_OK  = 8'd201;
  localparam logic [7:0] CODE_ERR_RUN = 8'd202;
  localparam logic [7:0] CODE_ERR_OK  = 8'd203;

  // Token kinds.
  localparam logic [2:0] KIND_IDENT = 3'd0;
  localparam logic [2:0] KIND_INT   = 3'd1;
  localparam logic [2:0] KIND_HEX   = 3'd2;
  localparam logic [2:0] KIND_EOT   = 3'd3;
  localparam logic [2:0] KIND_BAD   = 3'd4;
  localparam logic [2:0] KIND_ERR   = 3'd5;

  localparam int unsigned LenW = 8;

  // One queue entry: the first token of an item and whether an end-of-text
  // token follows it.
  typedef struct packed {
    logic [2:0]      kind;
    logic [LenW-1:0] len;
    logic            two;
  } tsd_entry_t;

  // Transition table, one row packed with class 7 in the top byte.
  function automatic logic [7:0] dfa_next(logic [2:0] row, logic [2:0] cls);
    logic [63:0] bits;
    case (row)
      3'd1:    bits = {8'd100, 8'd100, 8'd100, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
      3'd2:    bits = {8'd101, 8'd101, 8'd101, 8'd200, 8'd200, 8'd200, 8'd2, 8'd2};
      3'd3:    bits = {8'd101, 8'd101, 8'd101, 8'd200, 8'd4, 8'd200, 8'd2, 8'd2};
      3'd4:    bits = {8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd4, 8'd4, 8'd4};
      3'd5:    bits = {8'd201, 8'd201, 8'd201, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200};
      3'd6:    bits = {8'd202, 8'd203, 8'd203, 8'd203, 8'd203, 8'd203, 8'd203, 8'd203};
      default: bits = {8'd202, 8'd0, 8'd103, 8'd1, 8'd1, 8'd1, 8'd2, 8'd3};
    endcase
    return bits[{cls, 3'b000} +: 8];
  endfunction

  function automatic logic is_stop(logic [7:0] code);
    return (code >= CODE_ID_OK && code <= CODE_FDT_OK) ||
           code == CODE_BAD_OK || code == CODE_ERR_OK;
  endfunction

  function automatic logic [2:0] row_of(logic [7:0] code);
    logic [2:0] row;
    if (code == CODE_BAD_RUN) begin
      row = ROW_BAD;
    end else if (code == CODE_ERR_RUN) begin
      row = ROW_ERR;
    end else if (code < 8'd5) begin
      row = code[2:0];
    end else begin
      row = ROW_START;
    end
    return row;
  endfunction

  function automatic logic [2:0] kind_of(logic [7:0] code);
    logic [2:0] kind;
    case (code)
      CODE_ID_OK:  kind = KIND_IDENT;
      CODE_INT_OK: kind = KIND_INT;
      CODE_HEX_OK: kind = KIND_HEX;
      CODE_FDT_OK: kind = KIND_EOT;
      CODE_BAD_OK: kind = KIND_BAD;
      CODE_ERR_OK: kind = KIND_ERR;
      default:     kind = KIND_ERR;
    endcase
    return kind;
  endfunction

endpackage

>>> src/tsd_front.sv
`timescale 1ns / 1ps

module tsd_front #(
  parameter int unsigned MaxLexeme = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            char_byte_i,
  input  logic                  end_of_text_i,
  output logic                  push_o,
  output tsd_pkg::tsd_entry_t   entry_o
);

  localparam int unsigned CntW = $clog2(MaxLexeme + 1);
  localparam int unsigned WideW = (CntW > tsd_pkg::LenW) ? CntW : tsd_pkg::LenW;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      cls;
  logic [7:0]      code, again;
  logic            stop;
  logic [WideW-1:0] cnt_wide;
  logic [tsd_pkg::LenW-1:0] cnt_len;
  logic [CntW-1:0] cnt_bump;

  always_comb begin
    if (end_of_text_i) begin
      cls = tsd_pkg::CLS_END;
    end else if (char_byte_i == 8'h30) begin
      cls = tsd_pkg::CLS_ZERO;
    end else if (char_byte_i inside {[8'h31:8'h39]}) begin
      cls = tsd_pkg::CLS_DIGIT;
    end else if (char_byte_i inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      cls = tsd_pkg::CLS_HEX;
    end else if (char_byte_i == 8'h78 || char_byte_i == 8'h58) begin
      cls = tsd_pkg::CLS_X;
    end else if (char_byte_i inside {[8'h61:8'h7a], [8'h41:8'h5a]}) begin
      cls = tsd_pkg::CLS_ALPHA;
    end else if (char_byte_i inside {8'h20, [8'h09:8'h0d]}) begin
      cls = tsd_pkg::CLS_SPACE;
    end else begin
      cls = tsd_pkg::CLS_OTHER;
    end
  end

  assign cnt_wide = WideW'(cnt_q);
  assign cnt_len  = (cnt_wide > WideW'(255)) ? {tsd_pkg::LenW{1'b1}}
                                             : cnt_wide[tsd_pkg::LenW-1:0];
  assign cnt_bump = (cnt_q >= CntW'(MaxLexeme)) ? cnt_q : cnt_q + CntW'(1);

  assign code  = tsd_pkg::dfa_next(state_q, cls);
  assign again = tsd_pkg::dfa_next(tsd_pkg::ROW_START, cls);
  assign stop  = tsd_pkg::is_stop(code);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    entry_o.kind  = tsd_pkg::kind_of(code);
    entry_o.len   = (code == tsd_pkg::CODE_FDT_OK) ? '0 : cnt_len;
    entry_o.two   = 1'b0;
    if (!stop) begin
      state_d = tsd_pkg::row_of(code);
      cnt_d   = (code == 8'd0) ? '0 : cnt_bump;
    end else begin
      state_d = tsd_pkg::ROW_START;
      cnt_d   = '0;
      // The delimiter is scanned again from the start row.
      if (code != tsd_pkg::CODE_FDT_OK) begin
        if (tsd_pkg::is_stop(again)) begin
          entry_o.two = 1'b1;
        end else begin
          state_d = tsd_pkg::row_of(again);
          cnt_d   = (again == 8'd0) ? '0 : CntW'(1);
        end
      end
    end
  end

  assign push_o = accept_i & stop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsd_pkg::ROW_START;
      cnt_q   <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_state_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != 3'd7) else $error("scanner row out of range");

  a_eot_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.kind == tsd_pkg::KIND_EOT |-> entry_o.len == '0)
    else $error("end-of-text token with nonzero length");

  a_start_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.two |=> state_q == tsd_pkg::ROW_START && cnt_q == '0)
    else $error("scanner not back at start after end of text");

endmodule

>>> src/tsd_queue.sv
`timescale 1ns / 1ps

module tsd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tsd_pkg::tsd_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output tsd_pkg::tsd_entry_t head_o
);

  localparam int unsigned Depth = 2;

  tsd_pkg::tsd_entry_t mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(Depth));
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue underflow");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth)) else $error("queue count out of range");

endmodule

>>> src/tsd_back.sv
`timescale 1ns / 1ps

module tsd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  tsd_pkg::tsd_entry_t      head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               token_kind_o,
  output logic [tsd_pkg::LenW-1:0] lexeme_length_o,
  output logic                     last_o
);

  logic phase_q;
  logic beat;

  assign out_valid_o     = ~empty_i;
  assign token_kind_o    = phase_q ? tsd_pkg::KIND_EOT : head_i.kind;
  assign lexeme_length_o = phase_q ? '0 : head_i.len;
  assign last_o          = phase_q | ~head_i.two;
  assign beat            = out_valid_o & out_ready_i;
  assign pop_o           = beat & last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (beat) begin
      phase_q <= ~last_o;
    end
  end

  a_phase_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> out_valid_o && head_i.two) else $error("second beat without entry");

  a_phase_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q && out_ready_i |=> !phase_q) else $error("second beat not closed");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !last_o |=> phase_q) else $error("end-of-text beat skipped");

endmodule

>>> src/token_scanner_dfa.sv
`timescale 1ns / 1ps

// Character lexer. The input channel takes one beat per character: an 8-bit
// character, or the end-of-text flag, which ends the current token. The output
// channel returns one beat per token with its kind (identifier, integer, hex,
// end of text, malformed integer, general error) and its length, clamped to
// 255; last marks the final token caused by one input beat.
// A character is classified and stepped through the scanner table in the
// cycle it is accepted, so the input side takes one beat every cycle while
// the queue is not full. Its token, if any, is registered into the queue
// before it reaches the output. An end of text that closes an open token
// gives two output beats; every other input beat gives at most one.
// A two-entry queue sits between the scanner and the output sequencer. When
// the receiver stalls, the scanner keeps accepting characters that produce
// no token, and up to two queue entries, each a token plus any end of text,
// wait; only then does in_ready_o drop. Reset returns the scanner to its start
// row with an empty lexeme and empties the queue; no clearing pass is needed.
// MAX_LEXEME sets the saturation point of the internal character counter.
module token_scanner_dfa #(
  parameter int unsigned MAX_LEXEME = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               char_byte_i,
  input  logic                     end_of_text_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               token_kind_o,
  output logic [tsd_pkg::LenW-1:0] lexeme_length_o,
  output logic                     last_o
);

  tsd_pkg::tsd_entry_t new_entry;
  tsd_pkg::tsd_entry_t head;
  logic push, pop, full, empty, accept;

  // The scanner only stalls when a token might have nowhere to go.
  assign in_ready_o = ~full;
  assign accept     = in_valid_i & in_ready_o;

  tsd_front #(
    .MaxLexeme(MAX_LEXEME)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_byte_i  (char_byte_i),
    .end_of_text_i(end_of_text_i),
    .push_o       (push),
    .entry_o      (new_entry)
  );

  tsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(new_entry),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .head_o (head)
  );

  tsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .lexeme_length_o(lexeme_length_o),
    .last_o         (last_o)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

  // Scanner rows that the package does not name.
  localparam logic [2:0] ST_IDENT = 3'd1;
  localparam logic [2:0] ST_DEC   = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_HEX   = 3'd4;

  // Table entries that move to a row without closing a token.
  localparam logic [7:0] TO_START = 8'd0;
  localparam logic [7:0] TO_IDENT = 8'd1;
  localparam logic [7:0] TO_DEC   = 8'd2;
  localparam logic [7:0] TO_ZERO  = 8'd3;
  localparam logic [7:0] TO_HEX   = 8'd4;

  localparam int MAX_LEN = 255;

  typedef struct packed {
    logic [2:0]               kind;
    logic [tsd_pkg::LenW-1:0] len;
    logic                     last;
  } token_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [7:0]               char_byte_i = 8'h00;
  logic                     end_of_text_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [2:0]               token_kind_o;
  logic [tsd_pkg::LenW-1:0] lexeme_length_o;
  logic                     last_o;

  token_t     tokens_due[$];
  logic [2:0] scan_row = tsd_pkg::ROW_START;
  int         lex_len = 0;
  int         mismatches = 0;
  int         beats_sent = 0;
  int         hold_off = 0;
  bit         calm = 1'b0;

  token_scanner_dfa uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_byte_i     (char_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_kind_o    (token_kind_o),
    .lexeme_length_o (lexeme_length_o),
    .last_o          (last_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [2:0] char_class(input logic [7:0] ch, input logic eot);
    if (eot) return tsd_pkg::CLS_END;
    if (ch == "0") return tsd_pkg::CLS_ZERO;
    if (ch >= "1" && ch <= "9") return tsd_pkg::CLS_DIGIT;
    if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) return tsd_pkg::CLS_HEX;
    if (ch == "x" || ch == "X") return tsd_pkg::CLS_X;
    if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) return tsd_pkg::CLS_ALPHA;
    if (ch == " " || (ch >= 8'd9 && ch <= 8'd13)) return tsd_pkg::CLS_SPACE;
    return tsd_pkg::CLS_OTHER;
  endfunction

  // Entries are listed in class order, zero first.
  function automatic logic [7:0] next_code(input logic [2:0] row, input logic [2:0] cls);
    logic [0:7][7:0] r;
    case (row)
      ST_IDENT: r = {TO_IDENT, TO_IDENT, TO_IDENT, TO_IDENT, TO_IDENT,
                     tsd_pkg::CODE_ID_OK, tsd_pkg::CODE_ID_OK, tsd_pkg::CODE_ID_OK};
      ST_DEC:   r = {TO_DEC, TO_DEC, tsd_pkg::CODE_BAD_RUN, tsd_pkg::CODE_BAD_RUN,
                     tsd_pkg::CODE_BAD_RUN, tsd_pkg::CODE_INT_OK, tsd_pkg::CODE_INT_OK,
                     tsd_pkg::CODE_INT_OK};
      ST_ZERO:  r = {TO_DEC, TO_DEC, tsd_pkg::CODE_BAD_RUN, TO_HEX, tsd_pkg::CODE_BAD_RUN,
                     tsd_pkg::CODE_INT_OK, tsd_pkg::CODE_INT_OK, tsd_pkg::CODE_INT_OK};
      ST_HEX:   r = {TO_HEX, TO_HEX, TO_HEX, tsd_pkg::CODE_HEX_OK, tsd_pkg::CODE_HEX_OK,
                     tsd_pkg::CODE_HEX_OK, tsd_pkg::CODE_HEX_OK, tsd_pkg::CODE_HEX_OK};
      tsd_pkg::ROW_BAD:
                r = {tsd_pkg::CODE_BAD_RUN, tsd_pkg::CODE_BAD_RUN, tsd_pkg::CODE_BAD_RUN,
                     tsd_pkg::CODE_BAD_RUN, tsd_pkg::CODE_BAD_RUN, tsd_pkg::CODE_BAD_OK,
                     tsd_pkg::CODE_BAD_OK, tsd_pkg::CODE_BAD_OK};
      tsd_pkg::ROW_ERR:
                r = {tsd_pkg::CODE_ERR_OK, tsd_pkg::CODE_ERR_OK, tsd_pkg::CODE_ERR_OK,
                     tsd_pkg::CODE_ERR_OK, tsd_pkg::CODE_ERR_OK, tsd_pkg::CODE_ERR_OK,
                     tsd_pkg::CODE_ERR_OK, tsd_pkg::CODE_ERR_RUN};
      default:  r = {TO_ZERO, TO_DEC, TO_IDENT, TO_IDENT, TO_IDENT,
                     tsd_pkg::CODE_FDT_OK, TO_START, tsd_pkg::CODE_ERR_RUN};
    endcase
    return r[cls];
  endfunction

  function automatic bit closes_token(input logic [7:0] code);
    return (code >= tsd_pkg::CODE_ID_OK && code <= tsd_pkg::CODE_FDT_OK) ||
           code == tsd_pkg::CODE_BAD_OK || code == tsd_pkg::CODE_ERR_OK;
  endfunction

  function automatic logic [2:0] row_after(input logic [7:0] code);
    if (code == tsd_pkg::CODE_BAD_RUN) return tsd_pkg::ROW_BAD;
    if (code == tsd_pkg::CODE_ERR_RUN) return tsd_pkg::ROW_ERR;
    return code[2:0];
  endfunction

  function automatic logic [2:0] kind_for(input logic [7:0] code);
    case (code)
      tsd_pkg::CODE_ID_OK:  return tsd_pkg::KIND_IDENT;
      tsd_pkg::CODE_INT_OK: return tsd_pkg::KIND_INT;
      tsd_pkg::CODE_HEX_OK: return tsd_pkg::KIND_HEX;
      tsd_pkg::CODE_FDT_OK: return tsd_pkg::KIND_EOT;
      tsd_pkg::CODE_BAD_OK: return tsd_pkg::KIND_BAD;
      default:              return tsd_pkg::KIND_ERR;
    endcase
  endfunction

  // Steps the scanner copy by one accepted beat and queues the tokens it closes.
  function automatic void scan_beat(input logic [7:0] ch, input logic eot);
    logic [2:0] cls;
    logic [7:0] code;
    logic [7:0] again;
    token_t     tok;
    cls  = char_class(ch, eot);
    code = next_code(scan_row, cls);
    if (!closes_token(code)) begin
      scan_row = row_after(code);
      if (code == TO_START) lex_len = 0;
      else if (lex_len < MAX_LEN) lex_len++;
    end else begin
      tok.kind = kind_for(code);
      tok.len  = (code == tsd_pkg::CODE_FDT_OK) ? '0 : tsd_pkg::LenW'(lex_len);
      tok.last = 1'b1;
      scan_row = tsd_pkg::ROW_START;
      lex_len  = 0;
      if (code != tsd_pkg::CODE_FDT_OK) begin
        // The delimiter is scanned again from the start row.
        again = next_code(tsd_pkg::ROW_START, cls);
        if (closes_token(again)) begin
          tok.last = 1'b0;
          tokens_due.push_back(tok);
          tok.kind = kind_for(again);
          tok.len  = '0;
          tok.last = 1'b1;
        end else begin
          scan_row = row_after(again);
          lex_len  = (again == TO_START) ? 0 : 1;
        end
      end
      tokens_due.push_back(tok);
    end
  endfunction

  // ------------------------------------------------------------ token checker

  always @(posedge clk_i) begin : watch_tokens
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: token with nothing expected, got kind %0d len %0d last %0d",
                 $time, token_kind_o, lexeme_length_o, last_o);
        mismatches++;
      end else begin
        want = tokens_due.pop_front();
        if (token_kind_o !== want.kind) begin
          $display("%0t: token kind expected %0d, got %0d", $time, want.kind, token_kind_o);
          mismatches++;
        end
        if (lexeme_length_o !== want.len) begin
          $display("%0t: lexeme length expected %0d, got %0d",
                   $time, want.len, lexeme_length_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last flag expected %0d, got %0d", $time, want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // -------------------------------------------------------------- idle timing

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // The receiver stalls at random unless a hold-off is pending or idling is off.
  initial begin : token_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_ready_i <= 1'b0;
      end else if (calm || stall_left == 0) begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = idle_len();
      end else begin
        stall_left--;
        out_ready_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ sending

  task automatic send_beat(input logic [7:0] ch, input logic eot);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 35) gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_byte_i   <= ch;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scan_beat(ch, eot);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // The character field carries random bits; the flag alone counts.
  task automatic send_eot();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // The sender stops offering until every expected token has come back.
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tokens_due.size() != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 2) == 0) return rand_digit();
    return rand_letter();
  endfunction

  function automatic logic [7:0] rand_hexdig();
    case ($urandom_range(0, 2))
      0:       return rand_digit();
      1:       return 8'("a" + $urandom_range(0, 5));
      default: return 8'("A" + $urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    if ($urandom_range(0, 1)) return " ";
    return 8'($urandom_range(9, 13));
  endfunction

  // Anything outside letters, digits and whitespace, high bytes included.
  function automatic logic [7:0] rand_other();
    case ($urandom_range(0, 6))
      0:       return 8'($urandom_range(0, 8));
      1:       return 8'($urandom_range(14, 31));
      2:       return 8'($urandom_range(33, 47));
      3:       return 8'($urandom_range(58, 64));
      4:       return 8'($urandom_range(91, 96));
      5:       return 8'($urandom_range(123, 127));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // One lexeme of a random kind with random content, then a random delimiter or none.
  task automatic send_random_token();
    case ($urandom_range(0, 5))
      0: begin
        send_beat(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 7)) send_beat(rand_alnum(), 1'b0);
      end
      1: begin
        send_beat(8'("1" + $urandom_range(0, 8)), 1'b0);
        repeat ($urandom_range(0, 6)) send_beat(rand_digit(), 1'b0);
      end
      2: begin
        send_beat("0", 1'b0);
        send_beat($urandom_range(0, 1) ? "x" : "X", 1'b0);
        repeat ($urandom_range(0, 6)) send_beat(rand_hexdig(), 1'b0);
      end
      3: begin
        send_beat("0", 1'b0);
        repeat ($urandom_range(0, 3)) send_beat(rand_digit(), 1'b0);
      end
      4: begin
        repeat ($urandom_range(1, 2)) send_beat(rand_digit(), 1'b0);
        send_beat(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 3)) send_beat(rand_alnum(), 1'b0);
      end
      default: begin
        repeat ($urandom_range(1, 3)) send_beat(rand_other(), 1'b0);
      end
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: send_beat(rand_space(), 1'b0);
      4, 5:       send_beat(rand_other(), 1'b0);
      6:          send_eot();
      default:    ;
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 9) == 0) send_eot();
      else send_beat(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    send_eot();                // end of text with nothing open
    send_text(" ");            // leading whitespace is skipped
    send_text("Az0\v");        // identifier closed by whitespace
    send_text("0Xf9g+");       // hex ended by a letter, identifier ended by junk
    send_beat(8'hFF, 1'b0);
    send_text("1");            // unknown run closed by a digit
    send_eot();                // integer, then end of text
    send_text("07ax-");        // malformed integer run
    send_eot();
    send_text("0 ");           // lone zero
    send_text("0x");
    send_eot();                // bare prefix closed by end of text
    send_text("00");
    send_beat(8'h00, 1'b0);
    send_text("x");
    send_eot();
    drain_tokens();
  endtask

  task automatic test_random_tokens(input int beats);
    int stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) send_random_token();
      else send_noise();
    end
    drain_tokens();
  endtask

  // Tokens pile up behind a stalled receiver until the input side stalls too.
  task automatic test_output_stall();
    hold_off = 60;
    repeat (10) begin
      send_beat(rand_letter(), 1'b0);
      send_beat(rand_digit(), 1'b0);
      send_beat(rand_space(), 1'b0);
    end
    send_eot();
    drain_tokens();
  endtask

  task automatic test_long_lexemes();
    send_beat(rand_letter(), 1'b0);
    repeat (257) send_beat(rand_alnum(), 1'b0);
    send_eot();
    send_text("12z");
    repeat (256) send_beat(rand_alnum(), 1'b0);
    send_beat(rand_space(), 1'b0);
    drain_tokens();
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    test_random_tokens(80);
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_tokens(110);
    test_output_stall();
    test_back_to_back();
    test_long_lexemes();
    test_random_tokens(80);
    drain_tokens();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/tsd_pkg.sv
src/tsd_front.sv
src/tsd_queue.sv
src/tsd_back.sv
src/token_scanner_dfa.sv
test/tb.sv
